// ===== hw/rtl/paid_pkg.sv =====
// Shared types and codes for the positional insert/delete list.
// No dependencies; used by paid_cell and positional_array_insert_delete.
`default_nettype none

package paid_pkg;

  localparam logic [1:0] MODE_READ = 2'd0;
  localparam logic [1:0] MODE_INS  = 2'd1;
  localparam logic [1:0] MODE_DEL  = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_BADPOS = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;
  localparam logic [1:0] STAT_EMPTY  = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic signed [31:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/positional_array_insert_delete.sv =====
// Top level: ordered list of signed 32-bit entries with insert, delete, read-out.
// Depends on paid_pkg and paid_cell.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o | mode_i, position_i, value_i
//   out     | output    | out_valid_o/out_stall_i | status_o, element_o, last_o, entry_count_o
//
// Insert, delete and errors return one result each; the affected cells shift together.
// Read-out is accepted first; then, while the output is not held, the cells rotate and
// cell 0 is sent, one stored entry at a time.
// Reset clears state, count, read index and output valid; entry cells hold no reset value.
// Input is stalled during read-out and whenever the output register is held.
`default_nettype none

module positional_array_insert_delete #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [1:0]         mode_i,
  input  wire  [6:0]         position_i,
  input  wire  signed [31:0] value_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] element_o,
  output logic               last_o,
  output logic [6:0]         entry_count_o
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = ((CW > 7) ? CW : 7) + 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic               state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      rd_idx_q, rd_idx_d;
  logic               out_valid_q, out_valid_d;
  logic [1:0]         status_q, status_d;
  logic signed [31:0] element_q, element_d;
  logic               last_q, last_d;

  paid_pkg::cell_cmd_t cmd;
  logic signed [31:0]  cell_data [CAPACITY];

  logic            out_free, in_acc;
  logic [CMPW-1:0] pos_ext, cnt_ext;
  logic            ins_ok, ins_bad, ins_full, del_ok;
  logic [CW-1:0]   pos_idx, last_idx;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign pos_ext  = CMPW'(position_i);
  assign cnt_ext  = CMPW'(count_q);
  assign ins_bad  = (pos_ext == '0) || (pos_ext > cnt_ext + CMPW'(1));
  assign ins_full = (count_q == CW'(CAPACITY));
  assign ins_ok   = !ins_bad && !ins_full;
  assign del_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign pos_idx  = CW'(pos_ext - CMPW'(1));
  assign last_idx = count_q - CW'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    element_d   = element_q;
    last_d      = last_q;
    cmd.op      = paid_pkg::CELL_HOLD;
    cmd.value   = value_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_valid_d = 1'b1;
          status_d    = paid_pkg::STAT_OK;
          element_d   = '0;
          last_d      = 1'b1;
          unique case (mode_i)
            paid_pkg::MODE_READ: begin
              if (count_q == '0) begin
                status_d = paid_pkg::STAT_EMPTY;
              end else begin
                out_valid_d = 1'b0;
                rd_idx_d    = '0;
                state_d     = S_READ;
              end
            end
            paid_pkg::MODE_INS: begin
              if (ins_bad) begin
                status_d = paid_pkg::STAT_BADPOS;
              end else if (ins_full) begin
                status_d = paid_pkg::STAT_FULL;
              end else begin
                cmd.op  = paid_pkg::CELL_INS;
                count_d = count_q + CW'(1);
              end
            end
            paid_pkg::MODE_DEL: begin
              if (del_ok) begin
                cmd.op  = paid_pkg::CELL_DEL;
                count_d = count_q - CW'(1);
              end else begin
                status_d = paid_pkg::STAT_BADPOS;
              end
            end
            default: status_d = paid_pkg::STAT_BADPOS;
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd.op      = paid_pkg::CELL_ROT;
          out_valid_d = 1'b1;
          status_d    = paid_pkg::STAT_OK;
          element_d   = cell_data[0];
          last_d      = (rd_idx_q == last_idx);
          rd_idx_d    = rd_idx_q + CW'(1);
          if (rd_idx_q == last_idx) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = value_i;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    paid_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .pos_idx_i  (pos_idx),
      .last_idx_i (last_idx),
      .left_i     (left_w),
      .right_i    (right_w),
      .wrap_i     (cell_data[0]),
      .data_o     (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    element_q <= element_d;
    last_q    <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign element_o     = element_q;
  assign last_o        = last_q;
  assign entry_count_o = 7'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(count_q) <= CMPW'(CAPACITY))
    else $error("entry count above capacity");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (count_q != '0) && (rd_idx_q < count_q))
    else $error("read-out index out of range");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mode_i == paid_pkg::MODE_INS && ins_ok)
      |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the list");

  a_del_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mode_i == paid_pkg::MODE_DEL && del_ok)
      |=> (count_q == $past(count_q) - CW'(1)))
    else $error("delete did not shrink the list");

  a_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && out_free && rd_idx_q == last_idx)
      |=> (state_q == S_IDLE) && out_valid_q && last_q)
    else $error("read-out did not end on the last entry");

endmodule

`default_nettype wire

// ===== hw/rtl/paid_cell.sv =====
// One storage cell of the list chain; holds a single entry.
// Depends on paid_pkg for the broadcast command.
`default_nettype none

module paid_cell #(
  parameter int unsigned CW  = 7,
  parameter int unsigned IDX = 0
) (
  input  wire                      clk_i,
  input  wire paid_pkg::cell_cmd_t cmd_i,
  input  wire  [CW-1:0]            pos_idx_i,
  input  wire  [CW-1:0]            last_idx_i,
  input  wire  signed [31:0]       left_i,
  input  wire  signed [31:0]       right_i,
  input  wire  signed [31:0]       wrap_i,
  output logic signed [31:0]       data_o
);

  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  logic signed [31:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      paid_pkg::CELL_INS: begin
        if (MyIdx == pos_idx_i) data_d = cmd_i.value;
        else if (MyIdx > pos_idx_i) data_d = left_i;
      end
      paid_pkg::CELL_DEL: begin
        if (MyIdx >= pos_idx_i) data_d = right_i;
      end
      paid_pkg::CELL_ROT: begin
        if (MyIdx < last_idx_i) data_d = right_i;
        else if (MyIdx == last_idx_i) data_d = wrap_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== dv/paid_list_checker.sv =====
// Checker for positional_array_insert_delete: watches both channels, keeps a shadow list,
// predicts every result and compares field by field. Depends on paid_pkg.
`timescale 1ns / 1ps

module paid_list_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire               in_stall_i,
  input  wire        [1:0]  mode_i,
  input  wire        [6:0]  position_i,
  input  wire signed [31:0] value_i,
  input  wire               out_valid_i,
  input  wire               out_stall_i,
  input  wire        [1:0]  status_i,
  input  wire signed [31:0] element_i,
  input  wire               last_i,
  input  wire        [6:0]  entry_count_i,
  output int unsigned       errors_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o
);

  typedef struct {
    logic        [1:0]  status;
    logic signed [31:0] element;
    logic               last;
    logic        [6:0]  count;
  } list_result_t;

  logic signed [31:0] shadow_list [CAPACITY];
  int                 list_len;
  list_result_t       pending_results [$];
  int unsigned        error_count;
  int unsigned        pending_count;
  int unsigned        checked_count;

  assign errors_o  = error_count;
  assign pending_o = pending_count;
  assign checked_o = checked_count;

  initial begin
    error_count   = 0;
    pending_count = 0;
    checked_count = 0;
    list_len      = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic push_result(input logic [1:0] status, input logic signed [31:0] element,
                             input logic last);
    list_result_t r;
    r.status  = status;
    r.element = element;
    r.last    = last;
    r.count   = 7'(list_len);
    pending_results.push_back(r);
  endtask

  task automatic predict_list_op(input logic [1:0] mode, input logic [6:0] pos,
                                 input logic signed [31:0] val);
    int i;
    int p;
    p = int'(pos);
    case (mode)
      paid_pkg::MODE_READ: begin
        if (list_len == 0) begin
          push_result(paid_pkg::STAT_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < list_len; i++)
            push_result(paid_pkg::STAT_OK, shadow_list[i], (i == list_len - 1));
        end
      end
      paid_pkg::MODE_INS: begin
        // position check comes before the full check
        if (p < 1 || p > list_len + 1) begin
          push_result(paid_pkg::STAT_BADPOS, '0, 1'b1);
        end else if (list_len >= CAPACITY) begin
          push_result(paid_pkg::STAT_FULL, '0, 1'b1);
        end else begin
          for (i = list_len; i >= p; i--)
            shadow_list[i] = shadow_list[i - 1];
          shadow_list[p - 1] = val;
          list_len++;
          push_result(paid_pkg::STAT_OK, '0, 1'b1);
        end
      end
      paid_pkg::MODE_DEL: begin
        if (p < 1 || p > list_len) begin
          push_result(paid_pkg::STAT_BADPOS, '0, 1'b1);
        end else begin
          for (i = p - 1; i < list_len - 1; i++)
            shadow_list[i] = shadow_list[i + 1];
          list_len--;
          push_result(paid_pkg::STAT_OK, '0, 1'b1);
        end
      end
      default: begin
        push_result(paid_pkg::STAT_BADPOS, '0, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      pending_results.delete();
      list_len      = 0;
      pending_count = 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        predict_list_op(mode_i, position_i, value_i);
      if (out_valid_i && !out_stall_i) begin
        checked_count++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected transfer, status", 32'(status_i), '0);
        end else begin
          want = pending_results.pop_front();
          if (status_i !== want.status)
            report_mismatch("status", 32'(status_i), 32'(want.status));
          if (element_i !== want.element)
            report_mismatch("element", element_i, want.element);
          if (last_i !== want.last)
            report_mismatch("last", 32'(last_i), 32'(want.last));
          if (entry_count_i !== want.count)
            report_mismatch("entry_count", 32'(entry_count_i), 32'(want.count));
        end
      end
      pending_count = pending_results.size();
    end
  end

endmodule

// ===== dv/positional_array_insert_delete_tb.sv =====
// Testbench top for positional_array_insert_delete: clock, reset, directed and random
// list operations with random gaps and output stalls. Depends on paid_pkg and paid_list_checker.
`timescale 1ns / 1ps

module positional_array_insert_delete_tb;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned RAND_ITEMS = 220;
  localparam int unsigned RAND_MAX   = 300;
  localparam int unsigned MAX_GAP    = 30;
  localparam int unsigned MAX_ITEMS  = 25 + RAND_MAX + 3;
  localparam int unsigned LIMIT      = MAX_ITEMS * (CAPACITY * (MAX_GAP + 1) + MAX_GAP + 4) * 3;

  localparam logic [1:0]         MODE_UNUSED = 2'd3;
  localparam logic signed [31:0] VAL_MAX     = 32'sh7fffffff;
  localparam logic signed [31:0] VAL_MIN     = 32'sh80000000;

  typedef enum logic [1:0] {
    PICK_INS,
    PICK_DEL,
    PICK_READ,
    PICK_NOISE
  } pick_e;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic        [1:0]  mode;
  logic        [6:0]  position;
  logic signed [31:0] value_in;
  logic               out_valid;
  logic               out_stall;
  logic        [1:0]  out_status;
  logic signed [31:0] out_element;
  logic               out_last;
  logic        [6:0]  out_count;

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;
  int unsigned cycle_count;

  int          list_len;
  bit          quiet_in;
  bit          quiet_out;
  int unsigned stall_left;
  int unsigned n_ins, n_del, n_read, n_other;
  int unsigned full_hits, empty_hits;

  positional_array_insert_delete #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .mode_i       (mode),
    .position_i   (position),
    .value_i      (value_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (out_status),
    .element_o    (out_element),
    .last_o       (out_last),
    .entry_count_o(out_count)
  );

  paid_list_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .mode_i       (mode),
    .position_i   (position),
    .value_i      (value_in),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .status_i     (out_status),
    .element_i    (out_element),
    .last_i       (out_last),
    .entry_count_i(out_count),
    .errors_o     (errors),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(8, MAX_GAP);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 19))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // receiver stalls: random bursts, with stretches of none
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      quiet_out = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(20, 150)) begin
        @(negedge clk);
        if (stall_left != 0) begin
          out_stall  <= 1'b1;
          stall_left--;
        end else if (!quiet_out && $urandom_range(0, 99) < 25) begin
          out_stall  <= 1'b1;
          stall_left = gap_len() - 1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic idle(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_op(input logic [1:0] op, input logic [6:0] pos,
                         input logic signed [31:0] val);
    @(negedge clk);
    in_valid <= 1'b1;
    mode     <= op;
    position <= pos;
    value_in <= val;
    do @(posedge clk); while (in_stall);
    case (op)
      paid_pkg::MODE_INS: begin
        n_ins++;
        if (pos >= 1 && pos <= list_len + 1 && list_len < CAPACITY) list_len++;
      end
      paid_pkg::MODE_DEL: begin
        n_del++;
        if (pos >= 1 && pos <= list_len) list_len--;
      end
      paid_pkg::MODE_READ: n_read++;
      default:   n_other++;
    endcase
    if (!quiet_in && $urandom_range(0, 99) < 30) idle(gap_len());
  endtask

  task automatic random_op(input bit growing);
    int    r;
    pick_e pick;
    r = $urandom_range(0, 99);
    if (r < 72)      pick = growing ? PICK_INS : PICK_DEL;
    else if (r < 80) pick = growing ? PICK_DEL : PICK_INS;
    else if (r < 88) pick = PICK_READ;
    else             pick = PICK_NOISE;
    case (pick)
      PICK_INS:  send_op(paid_pkg::MODE_INS, 7'($urandom_range(1, list_len + 1)), rand_value());
      PICK_DEL: begin
        if (list_len == 0)
          send_op(paid_pkg::MODE_DEL, 7'($urandom_range(1, 127)), rand_value());
        else
          send_op(paid_pkg::MODE_DEL, 7'($urandom_range(1, list_len)), rand_value());
      end
      PICK_READ: send_op(paid_pkg::MODE_READ, 7'($urandom_range(0, 127)), rand_value());
      default: begin
        case ($urandom_range(0, 2))
          0: send_op(paid_pkg::MODE_INS,
                     $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(list_len + 2, 127)),
                     rand_value());
          1: send_op(paid_pkg::MODE_DEL,
                     $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(list_len + 1, 127)),
                     rand_value());
          default: send_op(MODE_UNUSED, 7'($urandom_range(0, 127)), rand_value());
        endcase
      end
    endcase
  endtask

  initial begin
    int unsigned n_rand;
    bit          growing;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    mode     = paid_pkg::MODE_READ;
    position = '0;
    value_in = '0;
    list_len = 0;
    quiet_in = 1'b1;
    n_ins = 0; n_del = 0; n_read = 0; n_other = 0;
    full_hits = 0; empty_hits = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty list, bad positions, ends and middle, unused mode
    send_op(paid_pkg::MODE_READ, 7'd0, '0);
    send_op(paid_pkg::MODE_DEL, 7'd1, '0);
    send_op(paid_pkg::MODE_INS, 7'd0, 32'sd5);
    send_op(paid_pkg::MODE_INS, 7'd2, 32'sd6);
    send_op(paid_pkg::MODE_INS, 7'd127, '1);
    send_op(paid_pkg::MODE_INS, 7'd1, VAL_MAX);
    send_op(paid_pkg::MODE_INS, 7'd2, VAL_MIN);
    send_op(paid_pkg::MODE_INS, 7'd1, '0);
    send_op(paid_pkg::MODE_INS, 7'd2, '1);
    send_op(paid_pkg::MODE_INS, 7'd5, 32'sh5a5a5a5a);
    send_op(paid_pkg::MODE_READ, 7'd127, '1);
    send_op(MODE_UNUSED, 7'd127, '1);
    send_op(paid_pkg::MODE_DEL, 7'd6, '0);
    send_op(paid_pkg::MODE_DEL, 7'd0, '0);
    send_op(paid_pkg::MODE_DEL, 7'd127, '0);
    send_op(paid_pkg::MODE_DEL, 7'd5, '0);
    send_op(paid_pkg::MODE_DEL, 7'd1, '0);
    send_op(paid_pkg::MODE_DEL, 7'd2, '0);
    send_op(paid_pkg::MODE_READ, 7'd0, '0);
    send_op(paid_pkg::MODE_INS, 7'd3, 32'sha5a5a5a5);
    send_op(paid_pkg::MODE_DEL, 7'd1, '0);
    send_op(paid_pkg::MODE_DEL, 7'd1, '0);
    send_op(paid_pkg::MODE_DEL, 7'd1, '0);
    send_op(paid_pkg::MODE_READ, 7'd0, '0);
    drain();

    // random: alternate growing to full and shrinking to empty
    n_rand  = 0;
    growing = 1'b1;
    while ((n_rand < RAND_ITEMS || full_hits == 0) && n_rand < RAND_MAX) begin
      if (n_rand % 32 == 0) quiet_in = ($urandom_range(0, 3) == 0);
      if (growing && list_len == CAPACITY) begin
        full_hits++;
        send_op(paid_pkg::MODE_INS, 7'($urandom_range(1, CAPACITY + 1)), rand_value());
        send_op(paid_pkg::MODE_INS, 7'(CAPACITY + 2), rand_value());
        send_op(paid_pkg::MODE_READ, 7'($urandom_range(0, 127)), rand_value());
        if (full_hits == 1) drain();
        growing = 1'b0;
        n_rand += 3;
      end else begin
        if (!growing && list_len == 0) begin
          empty_hits++;
          growing = 1'b1;
        end
        random_op(growing);
        n_rand++;
      end
    end

    drain();
    repeat (CAPACITY + 16) @(posedge clk);

    $display("sent %0d inserts, %0d deletes, %0d read-outs, %0d unused-mode ops; %0d results checked",
             n_ins, n_del, n_read, n_other, checked);
    $display("list reached capacity %0d time(s) and emptied again %0d time(s)",
             full_hits, empty_hits);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
